// File: hw/rtl/bicubic_bezier_patch_eval_macros.svh
// Assertion macros for the bicubic Bezier patch evaluator checker.
// Depends on nothing; the user supplies clock and reset in scope.
`ifndef BICUBIC_BEZIER_PATCH_EVAL_MACROS_SVH
`define BICUBIC_BEZIER_PATCH_EVAL_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define BBPE_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, active during reset as well.
`define BBPE_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/bbpe_pkg.sv
// Shared constants, types and helper functions of the Bezier patch evaluator.
// Used by the front queue, the evaluation engine and the top level.
`default_nettype none
package bbpe_pkg;

   localparam int COORD_WIDTH  = 32;
   localparam int UV_FRAC_BITS = 16;
   localparam int IN_COORD_W   = 32;
   localparam int UV_IN_W      = 17;
   localparam int POS_W        = 32;
   localparam int NORM_W       = 16;
   localparam int T_W          = UV_FRAC_BITS + 1;
   localparam int TAN_W        = COORD_WIDTH + 3;
   localparam int LP_W         = COORD_WIDTH + T_W + 2;
   localparam int OP_W         = 31;
   localparam int MP_W         = 2 * OP_W;
   localparam int CR_W         = 2 * OP_W + 1;
   localparam int SUM_W        = 2 * OP_W;
   localparam int SQ_W         = 64;
   localparam int ROOT_W       = OP_W;
   localparam int NUM_W        = OP_W + 16;
   localparam int DIV_W        = NUM_W + 1;
   localparam int QUO_W        = 16;
   localparam int QUEUE_DEPTH  = 2;
   localparam int QPTR_W       = 1;
   localparam int QCNT_W       = 2;
   localparam int NPTS         = 16;
   localparam int IDX_W        = 4;
   localparam int RAM_W        = 3 * COORD_WIDTH;

   localparam logic [T_W-1:0] UV_ONE = T_W'(1) << UV_FRAC_BITS;
   localparam longint TAN_LIMIT = longint'(1) << 30;
   localparam logic [QUO_W-1:0] NORM_MAX = QUO_W'(16384);

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_EVAL = 1'b1;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;
   typedef logic signed [TAN_W-1:0] tan_type;
   typedef logic signed [CR_W-1:0] cross_type;

   typedef struct packed {
      logic                 command;
      logic [IDX_W-1:0]     point_index;
      coord_type            x;
      coord_type            y;
      coord_type            z;
      logic [T_W-1:0]       u;
      logic [T_W-1:0]       v;
   } work_type;

   function automatic logic [T_W-1:0] clamp_uv(input logic [UV_IN_W-1:0] p);
      if (64'(p) > 64'(UV_ONE)) return UV_ONE;
      return T_W'(p);
   endfunction

   function automatic logic tan_big(input tan_type x);
      return (64'(x) >= TAN_LIMIT) || (64'(x) < -TAN_LIMIT);
   endfunction

   function automatic logic cross_big(input cross_type x);
      return (64'(x) >= TAN_LIMIT) || (64'(x) < -TAN_LIMIT);
   endfunction

   function automatic logic signed [POS_W-1:0] sat_pos(input coord_type x);
      if (64'(x) > 64'sh7fffffff) return 32'sh7fffffff;
      if (64'(x) < -64'sh80000000) return 32'sh80000000;
      return POS_W'(x);
   endfunction

   // Left operand of each de Casteljau step; the right one is the next point.
   function automatic logic [1:0] lerp_left(input logic [2:0] step);
      logic [1:0] sel;
      unique case (step)
         3'd0, 3'd3, 3'd5: sel = 2'd0;
         3'd1, 3'd4:       sel = 2'd1;
         3'd2:             sel = 2'd2;
         default:          sel = 2'd0;
      endcase
      return sel;
   endfunction

   // Points read for the fallback normal, in the order P7, P5, P15, P13.
   function automatic logic [IDX_W-1:0] fb_addr(input logic [1:0] k);
      logic [IDX_W-1:0] a;
      unique case (k)
         2'd0:    a = IDX_W'(7);
         2'd1:    a = IDX_W'(5);
         2'd2:    a = IDX_W'(15);
         default: a = IDX_W'(13);
      endcase
      return a;
   endfunction

endpackage
`default_nettype wire

// File: hw/rtl/bbpe_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package dependency.
`default_nettype none
module bbpe_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// File: hw/rtl/bbpe_front.sv
// Front end: accepts request words, clamps u and v, and queues commands in order.
// Depends on bbpe_pkg.
`default_nettype none
module bbpe_front (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire logic                                 req_command,
   input  wire logic [bbpe_pkg::IDX_W-1:0]           req_point_index,
   input  wire logic signed [bbpe_pkg::IN_COORD_W-1:0] req_coord_x,
   input  wire logic signed [bbpe_pkg::IN_COORD_W-1:0] req_coord_y,
   input  wire logic signed [bbpe_pkg::IN_COORD_W-1:0] req_coord_z,
   input  wire logic [bbpe_pkg::UV_IN_W-1:0]         req_u_param,
   input  wire logic [bbpe_pkg::UV_IN_W-1:0]         req_v_param,
   output bbpe_pkg::work_type                        q_head,
   output logic                                      q_valid,
   input  wire logic                                 q_pop
);

   bbpe_pkg::work_type ent_ff [bbpe_pkg::QUEUE_DEPTH];
   bbpe_pkg::work_type entry_in;
   logic [bbpe_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [bbpe_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [bbpe_pkg::QCNT_W-1:0] count_ff, count_in;
   logic push;
   logic pop;

   assign req_ready = (count_ff != bbpe_pkg::QCNT_W'(bbpe_pkg::QUEUE_DEPTH));
   assign q_valid   = (count_ff != '0);
   assign q_head    = ent_ff[rd_ptr_ff];
   assign push      = req_valid && req_ready;
   assign pop       = q_pop && q_valid;

   always_comb begin
      entry_in.command     = req_command;
      entry_in.point_index = req_point_index;
      entry_in.x           = bbpe_pkg::COORD_WIDTH'(req_coord_x);
      entry_in.y           = bbpe_pkg::COORD_WIDTH'(req_coord_y);
      entry_in.z           = bbpe_pkg::COORD_WIDTH'(req_coord_z);
      entry_in.u           = bbpe_pkg::clamp_uv(req_u_param);
      entry_in.v           = bbpe_pkg::clamp_uv(req_v_param);
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + bbpe_pkg::QCNT_W'(push) - bbpe_pkg::QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         ent_ff[wr_ptr_ff] <= entry_in;
      end
   end

endmodule
`default_nettype wire

// File: hw/rtl/bbpe_back.sv
// Evaluation engine: point store, shared de Casteljau lerp, cross product,
// bit-serial square root and divider, and the response register. Uses bbpe_pkg, bbpe_ram.
`default_nettype none
module bbpe_back (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  bbpe_pkg::work_type                      q_head,
   input  wire logic                               q_valid,
   output logic                                    q_pop,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic signed [bbpe_pkg::POS_W-1:0]       rsp_pos_x,
   output logic signed [bbpe_pkg::POS_W-1:0]       rsp_pos_y,
   output logic signed [bbpe_pkg::POS_W-1:0]       rsp_pos_z,
   output logic signed [bbpe_pkg::NORM_W-1:0]      rsp_norm_x,
   output logic signed [bbpe_pkg::NORM_W-1:0]      rsp_norm_y,
   output logic signed [bbpe_pkg::NORM_W-1:0]      rsp_norm_z,
   output logic                                    rsp_normal_degenerate
);

   localparam int CW = bbpe_pkg::COORD_WIDTH;
   localparam int F  = bbpe_pkg::UV_FRAC_BITS;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_FETCH = 4'd1;
   localparam logic [3:0] S_MUL   = 4'd2;
   localparam logic [3:0] S_ADD   = 4'd3;
   localparam logic [3:0] S_SHR   = 4'd4;
   localparam logic [3:0] S_CROSS = 4'd5;
   localparam logic [3:0] S_CHK   = 4'd6;
   localparam logic [3:0] S_FBSET = 4'd7;
   localparam logic [3:0] S_NSHR  = 4'd8;
   localparam logic [3:0] S_SQ    = 4'd9;
   localparam logic [3:0] S_SQRT  = 4'd10;
   localparam logic [3:0] S_DINIT = 4'd11;
   localparam logic [3:0] S_DIV   = 4'd12;
   localparam logic [3:0] S_OUT   = 4'd13;

   localparam logic signed [bbpe_pkg::LP_W-1:0] RND = bbpe_pkg::LP_W'(1) << (F - 1);

   logic [3:0] state_ff;
   logic [bbpe_pkg::T_W-1:0] u_ff, v_ff, t_sel;
   logic [1:0] pass_ff, curve_ff;
   logic [2:0] fetch_ff, step_ff;
   logic [1:0] fetch_m1, li;
   logic fb_ff, deg_ff;
   bbpe_pkg::coord_type p_ff [4][3];
   bbpe_pkg::coord_type sh_ff [4][3];
   bbpe_pkg::coord_type pos_ff [3];
   bbpe_pkg::coord_type rd_c [3];
   bbpe_pkg::coord_type lerp_res [3];
   bbpe_pkg::tan_type der [3];
   logic signed [bbpe_pkg::LP_W-1:0] prod_ff [3];
   logic signed [bbpe_pkg::LP_W-1:0] prod_in [3];
   bbpe_pkg::tan_type va_ff [3];
   bbpe_pkg::tan_type vb_ff [3];
   logic big_a, big_b, big_n, n_nonzero;
   logic [3:0] cstep_ff;
   logic signed [bbpe_pkg::OP_W-1:0] opa, opb, nsq;
   logic signed [bbpe_pkg::MP_W-1:0] mprod_ff;
   bbpe_pkg::cross_type n_ff [3];
   logic [bbpe_pkg::SUM_W-1:0] ssum_ff, ssum_nx;
   logic [bbpe_pkg::SQ_W-1:0] sqx_ff, sqr_ff, sqb_ff, sq_sum;
   logic [bbpe_pkg::ROOT_W-1:0] len_ff;
   logic [1:0] comp_ff;
   logic [3:0] dcnt_ff;
   logic [bbpe_pkg::NUM_W-1:0] rem_ff;
   logic [bbpe_pkg::DIV_W-1:0] dsh;
   logic [bbpe_pkg::QUO_W-1:0] quo_ff, quo_nx, quo_cl;
   logic dhit;
   bbpe_pkg::cross_type ncur, nmag;
   logic signed [bbpe_pkg::NORM_W-1:0] nrm_ff [3];
   logic signed [bbpe_pkg::NORM_W-1:0] nrm_val;
   logic ram_we;
   logic [bbpe_pkg::IDX_W-1:0] ram_raddr;
   logic [bbpe_pkg::RAM_W-1:0] ram_rdata;
   logic rsp_valid_ff;
   logic signed [bbpe_pkg::POS_W-1:0] rsp_pos_ff [3];
   logic signed [bbpe_pkg::NORM_W-1:0] rsp_norm_ff [3];
   logic rsp_deg_ff;

   assign q_pop  = (state_ff == S_IDLE) && q_valid;
   assign ram_we = q_pop && (q_head.command == bbpe_pkg::CMD_LOAD);

   bbpe_ram #(.WIDTH(bbpe_pkg::RAM_W), .DEPTH(bbpe_pkg::NPTS)) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (q_head.point_index),
      .wr_data ({q_head.x, q_head.y, q_head.z}),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   always_comb begin
      if (fb_ff) begin
         ram_raddr = bbpe_pkg::fb_addr(fetch_ff[1:0]);
      end else if (pass_ff == 2'd0) begin
         ram_raddr = {fetch_ff[1:0], curve_ff};
      end else begin
         ram_raddr = {curve_ff, fetch_ff[1:0]};
      end
      rd_c[0]  = ram_rdata[3*CW-1:2*CW];
      rd_c[1]  = ram_rdata[2*CW-1:CW];
      rd_c[2]  = ram_rdata[CW-1:0];
      fetch_m1 = 2'(fetch_ff - 3'd1);
      t_sel    = (pass_ff == 2'd0 || pass_ff == 2'd3) ? u_ff : v_ff;
      li       = bbpe_pkg::lerp_left(step_ff);
      for (int c = 0; c < 3; c++) begin
         prod_in[c]  = ((CW + 1)'(p_ff[li + 2'd1][c]) - (CW + 1)'(p_ff[li][c]))
                       * $signed({1'b0, t_sel});
         lerp_res[c] = p_ff[li][c] + CW'((prod_ff[c] + RND) >>> F);
         der[c]      = ((bbpe_pkg::TAN_W'(p_ff[1][c]) - bbpe_pkg::TAN_W'(p_ff[0][c])) <<< 1)
                       + (bbpe_pkg::TAN_W'(p_ff[1][c]) - bbpe_pkg::TAN_W'(p_ff[0][c]));
      end
      big_a = bbpe_pkg::tan_big(va_ff[0]) || bbpe_pkg::tan_big(va_ff[1])
              || bbpe_pkg::tan_big(va_ff[2]);
      big_b = bbpe_pkg::tan_big(vb_ff[0]) || bbpe_pkg::tan_big(vb_ff[1])
              || bbpe_pkg::tan_big(vb_ff[2]);
      big_n = bbpe_pkg::cross_big(n_ff[0]) || bbpe_pkg::cross_big(n_ff[1])
              || bbpe_pkg::cross_big(n_ff[2]);
      n_nonzero = (n_ff[0] != '0) || (n_ff[1] != '0) || (n_ff[2] != '0);
      unique case (cstep_ff[3:1])
         3'd0:    begin opa = bbpe_pkg::OP_W'(va_ff[1]); opb = bbpe_pkg::OP_W'(vb_ff[2]); end
         3'd1:    begin opa = bbpe_pkg::OP_W'(va_ff[2]); opb = bbpe_pkg::OP_W'(vb_ff[1]); end
         3'd2:    begin opa = bbpe_pkg::OP_W'(va_ff[2]); opb = bbpe_pkg::OP_W'(vb_ff[0]); end
         3'd3:    begin opa = bbpe_pkg::OP_W'(va_ff[0]); opb = bbpe_pkg::OP_W'(vb_ff[2]); end
         3'd4:    begin opa = bbpe_pkg::OP_W'(va_ff[0]); opb = bbpe_pkg::OP_W'(vb_ff[1]); end
         3'd5:    begin opa = bbpe_pkg::OP_W'(va_ff[1]); opb = bbpe_pkg::OP_W'(vb_ff[0]); end
         default: begin opa = bbpe_pkg::OP_W'(va_ff[0]); opb = bbpe_pkg::OP_W'(vb_ff[0]); end
      endcase
      nsq     = bbpe_pkg::OP_W'(n_ff[cstep_ff[2:1]]);
      ssum_nx = ssum_ff + bbpe_pkg::SUM_W'(mprod_ff);
      sq_sum  = sqr_ff + sqb_ff;
      ncur    = n_ff[comp_ff];
      nmag    = ncur[bbpe_pkg::CR_W-1] ? -ncur : ncur;
      dsh     = bbpe_pkg::DIV_W'({len_ff, 1'b0}) << dcnt_ff;
      dhit    = bbpe_pkg::DIV_W'(rem_ff) >= dsh;
      quo_nx  = quo_ff | (dhit ? (bbpe_pkg::QUO_W'(1) << dcnt_ff) : '0);
      quo_cl  = (quo_nx > bbpe_pkg::NORM_MAX) ? bbpe_pkg::NORM_MAX : quo_nx;
      nrm_val = ncur[bbpe_pkg::CR_W-1] ? -$signed(quo_cl) : $signed(quo_cl);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (state_ff == S_OUT && (!rsp_valid_ff || rsp_ready)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (q_valid && q_head.command == bbpe_pkg::CMD_EVAL) begin
                  u_ff     <= q_head.u;
                  v_ff     <= q_head.v;
                  pass_ff  <= 2'd0;
                  curve_ff <= 2'd0;
                  fetch_ff <= 3'd0;
                  fb_ff    <= 1'b0;
                  deg_ff   <= 1'b0;
                  state_ff <= S_FETCH;
               end
            end
            S_FETCH: begin
               if (fetch_ff != 3'd0) begin
                  for (int c = 0; c < 3; c++) p_ff[fetch_m1][c] <= rd_c[c];
               end
               fetch_ff <= fetch_ff + 3'd1;
               if (fetch_ff == 3'd4) begin
                  step_ff  <= 3'd0;
                  state_ff <= fb_ff ? S_FBSET : S_MUL;
               end
            end
            S_MUL: begin
               for (int c = 0; c < 3; c++) prod_ff[c] <= prod_in[c];
               state_ff <= S_ADD;
            end
            S_ADD: begin
               if (step_ff != 3'd5) begin
                  for (int c = 0; c < 3; c++) p_ff[li][c] <= lerp_res[c];
                  step_ff  <= step_ff + 3'd1;
                  state_ff <= S_MUL;
               end else begin
                  unique case (pass_ff)
                     2'd0, 2'd2: begin
                        for (int c = 0; c < 3; c++) begin
                           sh_ff[0][c] <= sh_ff[1][c];
                           sh_ff[1][c] <= sh_ff[2][c];
                           sh_ff[2][c] <= sh_ff[3][c];
                           sh_ff[3][c] <= lerp_res[c];
                        end
                        if (curve_ff == 2'd3) begin
                           for (int c = 0; c < 3; c++) begin
                              p_ff[0][c] <= sh_ff[1][c];
                              p_ff[1][c] <= sh_ff[2][c];
                              p_ff[2][c] <= sh_ff[3][c];
                              p_ff[3][c] <= lerp_res[c];
                           end
                           pass_ff  <= pass_ff + 2'd1;
                           step_ff  <= 3'd0;
                           state_ff <= S_MUL;
                        end else begin
                           curve_ff <= curve_ff + 2'd1;
                           fetch_ff <= 3'd0;
                           state_ff <= S_FETCH;
                        end
                     end
                     2'd1: begin
                        for (int c = 0; c < 3; c++) va_ff[c] <= der[c];
                        pass_ff  <= 2'd2;
                        curve_ff <= 2'd0;
                        fetch_ff <= 3'd0;
                        state_ff <= S_FETCH;
                     end
                     default: begin
                        for (int c = 0; c < 3; c++) begin
                           vb_ff[c]  <= der[c];
                           pos_ff[c] <= lerp_res[c];
                        end
                        state_ff <= S_SHR;
                     end
                  endcase
               end
            end
            S_SHR: begin
               if (big_a) begin
                  for (int c = 0; c < 3; c++) va_ff[c] <= va_ff[c] >>> 1;
               end
               if (big_b) begin
                  for (int c = 0; c < 3; c++) vb_ff[c] <= vb_ff[c] >>> 1;
               end
               if (!big_a && !big_b) begin
                  cstep_ff <= 4'd0;
                  state_ff <= S_CROSS;
               end
            end
            S_CROSS: begin
               if (!cstep_ff[0]) begin
                  mprod_ff <= opa * opb;
               end else if (!cstep_ff[1]) begin
                  n_ff[cstep_ff[3:2]] <= bbpe_pkg::CR_W'(mprod_ff);
               end else begin
                  n_ff[cstep_ff[3:2]] <= n_ff[cstep_ff[3:2]] - bbpe_pkg::CR_W'(mprod_ff);
               end
               cstep_ff <= cstep_ff + 4'd1;
               if (cstep_ff == 4'd11) begin
                  state_ff <= S_CHK;
               end
            end
            S_CHK: begin
               if (n_nonzero) begin
                  state_ff <= S_NSHR;
               end else if (!fb_ff) begin
                  fb_ff    <= 1'b1;
                  fetch_ff <= 3'd0;
                  state_ff <= S_FETCH;
               end else begin
                  deg_ff   <= 1'b1;
                  state_ff <= S_OUT;
               end
            end
            S_FBSET: begin
               for (int c = 0; c < 3; c++) begin
                  va_ff[c] <= bbpe_pkg::TAN_W'(p_ff[0][c]) - bbpe_pkg::TAN_W'(p_ff[1][c]);
                  vb_ff[c] <= bbpe_pkg::TAN_W'(p_ff[2][c]) - bbpe_pkg::TAN_W'(p_ff[3][c]);
               end
               state_ff <= S_SHR;
            end
            S_NSHR: begin
               if (big_n) begin
                  for (int c = 0; c < 3; c++) n_ff[c] <= n_ff[c] >>> 1;
               end else begin
                  cstep_ff <= 4'd0;
                  ssum_ff  <= '0;
                  state_ff <= S_SQ;
               end
            end
            S_SQ: begin
               if (!cstep_ff[0]) begin
                  mprod_ff <= nsq * nsq;
               end else begin
                  ssum_ff <= ssum_nx;
               end
               cstep_ff <= cstep_ff + 4'd1;
               if (cstep_ff == 4'd5) begin
                  sqx_ff   <= bbpe_pkg::SQ_W'(ssum_nx);
                  sqr_ff   <= '0;
                  sqb_ff   <= bbpe_pkg::SQ_W'(1) << 62;
                  state_ff <= S_SQRT;
               end
            end
            S_SQRT: begin
               if (sqb_ff != '0) begin
                  if (sqx_ff >= sq_sum) begin
                     sqx_ff <= sqx_ff - sq_sum;
                     sqr_ff <= (sqr_ff >> 1) + sqb_ff;
                  end else begin
                     sqr_ff <= sqr_ff >> 1;
                  end
                  sqb_ff <= sqb_ff >> 2;
               end else begin
                  len_ff   <= (sqr_ff == '0) ? bbpe_pkg::ROOT_W'(1)
                                             : bbpe_pkg::ROOT_W'(sqr_ff);
                  comp_ff  <= 2'd0;
                  state_ff <= S_DINIT;
               end
            end
            S_DINIT: begin
               rem_ff   <= (bbpe_pkg::NUM_W'(nmag[bbpe_pkg::OP_W-1:0]) << 15)
                           + bbpe_pkg::NUM_W'(len_ff);
               quo_ff   <= '0;
               dcnt_ff  <= 4'd15;
               state_ff <= S_DIV;
            end
            S_DIV: begin
               if (dhit) begin
                  rem_ff <= bbpe_pkg::NUM_W'(bbpe_pkg::DIV_W'(rem_ff) - dsh);
               end
               quo_ff  <= quo_nx;
               dcnt_ff <= dcnt_ff - 4'd1;
               if (dcnt_ff == 4'd0) begin
                  nrm_ff[comp_ff] <= nrm_val;
                  comp_ff  <= comp_ff + 2'd1;
                  state_ff <= (comp_ff == 2'd2) ? S_OUT : S_DINIT;
               end
            end
            S_OUT: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  for (int c = 0; c < 3; c++) begin
                     rsp_pos_ff[c]  <= bbpe_pkg::sat_pos(pos_ff[c]);
                     rsp_norm_ff[c] <= deg_ff ? '0 : nrm_ff[c];
                  end
                  rsp_deg_ff   <= deg_ff;
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_pos_x             = rsp_pos_ff[0];
   assign rsp_pos_y             = rsp_pos_ff[1];
   assign rsp_pos_z             = rsp_pos_ff[2];
   assign rsp_norm_x            = rsp_norm_ff[0];
   assign rsp_norm_y            = rsp_norm_ff[1];
   assign rsp_norm_z            = rsp_norm_ff[2];
   assign rsp_normal_degenerate = rsp_deg_ff;

endmodule
`default_nettype wire

// File: hw/rtl/bicubic_bezier_patch_eval.sv
// Bicubic Bezier patch evaluator. A load word writes one of the 16 control points.
// An evaluate word runs ten cubic curves through one shared three-lane lerp unit
// (eight fetched curves and two combining ones), then the cross product and the
// fallback normal when needed; unless the normal is degenerate, the normal scaling,
// a 32-step square root and three 16-step divides follow.
// Words are taken into a two-entry queue while an evaluation is in progress, and
// a finished result waits in its own register while the next word is worked on.
// Commands are carried out in arrival order. Uses bbpe_pkg, bbpe_front, bbpe_back.
`default_nettype none
module bicubic_bezier_patch_eval (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_valid,
   output logic                                        req_ready,
   input  wire logic                                   req_command,
   input  wire logic [bbpe_pkg::IDX_W-1:0]             req_point_index,
   input  wire logic signed [bbpe_pkg::IN_COORD_W-1:0] req_coord_x,
   input  wire logic signed [bbpe_pkg::IN_COORD_W-1:0] req_coord_y,
   input  wire logic signed [bbpe_pkg::IN_COORD_W-1:0] req_coord_z,
   input  wire logic [bbpe_pkg::UV_IN_W-1:0]           req_u_param,
   input  wire logic [bbpe_pkg::UV_IN_W-1:0]           req_v_param,
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_ready,
   output logic signed [bbpe_pkg::POS_W-1:0]           rsp_pos_x,
   output logic signed [bbpe_pkg::POS_W-1:0]           rsp_pos_y,
   output logic signed [bbpe_pkg::POS_W-1:0]           rsp_pos_z,
   output logic signed [bbpe_pkg::NORM_W-1:0]          rsp_norm_x,
   output logic signed [bbpe_pkg::NORM_W-1:0]          rsp_norm_y,
   output logic signed [bbpe_pkg::NORM_W-1:0]          rsp_norm_z,
   output logic                                        rsp_normal_degenerate
);

   bbpe_pkg::work_type q_head;
   logic q_valid;
   logic q_pop;

   bbpe_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_command     (req_command),
      .req_point_index (req_point_index),
      .req_coord_x     (req_coord_x),
      .req_coord_y     (req_coord_y),
      .req_coord_z     (req_coord_z),
      .req_u_param     (req_u_param),
      .req_v_param     (req_v_param),
      .q_head          (q_head),
      .q_valid         (q_valid),
      .q_pop           (q_pop)
   );

   bbpe_back u_back (
      .clock                 (clock),
      .reset                 (reset),
      .q_head                (q_head),
      .q_valid               (q_valid),
      .q_pop                 (q_pop),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_pos_x             (rsp_pos_x),
      .rsp_pos_y             (rsp_pos_y),
      .rsp_pos_z             (rsp_pos_z),
      .rsp_norm_x            (rsp_norm_x),
      .rsp_norm_y            (rsp_norm_y),
      .rsp_norm_z            (rsp_norm_z),
      .rsp_normal_degenerate (rsp_normal_degenerate)
   );

endmodule
`default_nettype wire

// File: hw/rtl/bbpe_checker.sv
// Port-level checks for the patch evaluator, bound to the top level.
// Depends on bbpe_pkg and bicubic_bezier_patch_eval_macros.svh.
`default_nettype none
`include "bicubic_bezier_patch_eval_macros.svh"
module bbpe_checker (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  rsp_valid,
   input  wire logic                                  rsp_ready,
   input  wire logic signed [bbpe_pkg::NORM_W-1:0]    rsp_norm_x,
   input  wire logic signed [bbpe_pkg::NORM_W-1:0]    rsp_norm_y,
   input  wire logic signed [bbpe_pkg::NORM_W-1:0]    rsp_norm_z,
   input  wire logic                                  rsp_normal_degenerate
);

   `BBPE_ASSERT_NEXT(a_rsp_hold, !reset && rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_norm_x) && $stable(rsp_normal_degenerate), "result word changed before it was taken")
   `BBPE_ASSERT_NEXT(a_reset_clears, reset, !rsp_valid, "result valid after reset")
   `BBPE_ASSERT_NOW(a_norm_range, rsp_valid, rsp_norm_x >= -16'sd16384 && rsp_norm_x <= 16'sd16384 && rsp_norm_y >= -16'sd16384 && rsp_norm_y <= 16'sd16384 && rsp_norm_z >= -16'sd16384 && rsp_norm_z <= 16'sd16384, "normal component out of range")
   `BBPE_ASSERT_NOW(a_degen_zero, rsp_valid && rsp_normal_degenerate, rsp_norm_x == '0 && rsp_norm_y == '0 && rsp_norm_z == '0, "degenerate word with nonzero normal")
   `BBPE_ASSERT_NOW(a_unit_nonzero, rsp_valid && !rsp_normal_degenerate, rsp_norm_x != '0 || rsp_norm_y != '0 || rsp_norm_z != '0, "unit normal is zero")

endmodule

bind bicubic_bezier_patch_eval bbpe_checker u_checker (.*);
`default_nettype wire

// File: tb/tb_top.sv
// Self-checking testbench for the bicubic Bezier patch evaluator.
// Predicts surface points and unit normals in a scoreboard class; uses bbpe_pkg.
`default_nettype none

typedef struct {
   logic signed [31:0] pos [3];
   logic signed [15:0] norm [3];
   logic               degen;
} surface_point_type;

class patch_scoreboard;
   longint            ctrl [3][16];
   surface_point_type pending_points [$];
   int                mismatches;
   int                loads;
   int                evals;
   int                fallbacks;
   int                degenerates;

   function void reset_store();
      for (int k = 0; k < 3; k++)
         for (int i = 0; i < 16; i++)
            ctrl[k][i] = 0;
   endfunction

   function longint blend(longint a, longint b, longint t);
      longint d, dh, dl, r;
      d  = b - a;
      dh = d >>> 16;
      dl = d - (dh <<< 16);
      r  = (dl * t + 32768) >>> 16;
      return a + dh * t + r;
   endfunction

   function void casteljau(longint p0, longint p1, longint p2, longint p3, longint t,
                           output longint pos, output longint der);
      longint a, b, c, d, e;
      a = blend(p0, p1, t);
      b = blend(p1, p2, t);
      c = blend(p2, p3, t);
      d = blend(a, b, t);
      e = blend(b, c, t);
      pos = blend(d, e, t);
      der = 3 * (e - d);
   endfunction

   function void scale_down(inout longint w [3]);
      longint lim;
      lim = longint'(1) <<< 30;
      for (int n = 0; n < 64; n++) begin
         if (!(w[0] >= lim || w[0] < -lim || w[1] >= lim || w[1] < -lim ||
               w[2] >= lim || w[2] < -lim))
            return;
         for (int k = 0; k < 3; k++)
            w[k] = w[k] >>> 1;
      end
   endfunction

   function bit cross3(longint a0 [3], longint b0 [3], output longint n [3]);
      longint a [3], b [3];
      a = a0;
      b = b0;
      scale_down(a);
      scale_down(b);
      n[0] = a[1] * b[2] - a[2] * b[1];
      n[1] = a[2] * b[0] - a[0] * b[2];
      n[2] = a[0] * b[1] - a[1] * b[0];
      return n[0] != 0 || n[1] != 0 || n[2] != 0;
   endfunction

   function longint unsigned int_sqrt(longint unsigned x);
      longint unsigned r, bit_val;
      r = 0;
      bit_val = 64'd1 << 62;
      while (bit_val > x)
         bit_val >>= 2;
      while (bit_val != 0) begin
         if (x >= r + bit_val) begin
            x -= r + bit_val;
            r = (r >> 1) + bit_val;
         end else begin
            r >>= 1;
         end
         bit_val >>= 2;
      end
      return r;
   endfunction

   function void note_word(logic cmd, logic [3:0] idx, logic signed [31:0] x,
                           logic signed [31:0] y, logic signed [31:0] z,
                           logic [16:0] u_in, logic [16:0] v_in);
      surface_point_type sp;
      longint u, v, dummy, gpos, p [16];
      longint vc [4], uc [4], pos [3], tv [3], tu [3], n [3], a [3], b [3];
      longint unsigned s, len, m, q;
      if (cmd == bbpe_pkg::CMD_LOAD) begin
         ctrl[0][idx] = x;
         ctrl[1][idx] = y;
         ctrl[2][idx] = z;
         loads++;
         return;
      end
      evals++;
      u = (u_in > 65536) ? 65536 : u_in;
      v = (v_in > 65536) ? 65536 : v_in;
      for (int k = 0; k < 3; k++) begin
         p = ctrl[k];
         for (int j = 0; j < 4; j++) begin
            casteljau(p[j], p[j+4], p[j+8], p[j+12], u, vc[j], dummy);
            casteljau(p[4*j], p[4*j+1], p[4*j+2], p[4*j+3], v, uc[j], dummy);
         end
         casteljau(vc[0], vc[1], vc[2], vc[3], v, gpos, tv[k]);
         casteljau(uc[0], uc[1], uc[2], uc[3], u, pos[k], tu[k]);
         sp.pos[k] = pos[k] > 64'sh7fffffff ? 32'sh7fffffff :
                     pos[k] < -64'sh80000000 ? 32'sh80000000 : 32'(pos[k]);
      end
      sp.degen = 1'b0;
      if (!cross3(tv, tu, n)) begin
         fallbacks++;
         for (int k = 0; k < 3; k++) begin
            a[k] = ctrl[k][7] - ctrl[k][5];
            b[k] = ctrl[k][15] - ctrl[k][13];
         end
         if (!cross3(a, b, n))
            sp.degen = 1'b1;
      end
      if (sp.degen) begin
         degenerates++;
         for (int k = 0; k < 3; k++)
            sp.norm[k] = '0;
      end else begin
         scale_down(n);
         s = 0;
         for (int k = 0; k < 3; k++)
            s += longint'(n[k] * n[k]);
         len = int_sqrt(s);
         if (len == 0)
            len = 1;
         for (int k = 0; k < 3; k++) begin
            m = n[k] < 0 ? -n[k] : n[k];
            q = (m * 32768 + len) / (2 * len);
            if (q > 16384)
               q = 16384;
            sp.norm[k] = n[k] < 0 ? -16'(q) : 16'(q);
         end
      end
      pending_points = {pending_points, sp};
   endfunction

   function void check_result(surface_point_type got);
      surface_point_type want;
      bit bad;
      if (pending_points.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("Unexpected result word at %0t", $realtime);
         return;
      end
      want = pending_points.pop_front();
      bad = got.degen !== want.degen;
      for (int k = 0; k < 3; k++)
         if (got.pos[k] !== want.pos[k] || got.norm[k] !== want.norm[k])
            bad = 1;
      if (bad) begin
         mismatches++;
         if (mismatches <= 10) begin
            $display("Mismatch: want pos %0d %0d %0d norm %0d %0d %0d deg %0d,",
                     want.pos[0], want.pos[1], want.pos[2], want.norm[0], want.norm[1],
                     want.norm[2], want.degen);
            $display("          got pos %0d %0d %0d norm %0d %0d %0d deg %0d",
                     got.pos[0], got.pos[1], got.pos[2],
                     got.norm[0], got.norm[1], got.norm[2], got.degen);
         end
      end
   endfunction
endclass

module tb_top;

   localparam int LIMIT = 4000000;

   logic               clock = 0;
   logic               reset = 1;
   logic               req_valid = 0, req_ready;
   logic               req_command = 0;
   logic [3:0]         req_point_index = 0;
   logic signed [31:0] req_coord_x = 0, req_coord_y = 0, req_coord_z = 0;
   logic [16:0]        req_u_param = 0, req_v_param = 0;
   logic               rsp_valid, rsp_ready = 0;
   logic signed [31:0] rsp_pos_x, rsp_pos_y, rsp_pos_z;
   logic signed [15:0] rsp_norm_x, rsp_norm_y, rsp_norm_z;
   logic               rsp_normal_degenerate;

   patch_scoreboard sb = new();
   int  cycles = 0;
   int  sent = 0;
   bit  hold_request = 0;
   bit  drained = 0;

   bicubic_bezier_patch_eval dut (.*);

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   function int pick_gap();
      int r;
      r = $urandom_range(99);
      if (r < 70) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(20, 60);
   endfunction

   function logic signed [31:0] pick_coord();
      int r;
      r = $urandom_range(9);
      if (r < 5) return $signed($urandom_range(0, 1 << 21)) - (1 << 20);
      if (r == 5) return 32'sh7fffffff;
      if (r == 6) return 32'sh80000000;
      return $urandom;
   endfunction

   function logic [16:0] pick_param();
      int r;
      r = $urandom_range(9);
      if (r == 0) return 17'd0;
      if (r == 1) return 17'd65536;
      if (r == 2) return 17'($urandom_range(65537, 131071));
      return 17'($urandom_range(0, 65535));
   endfunction

   task send_word(logic cmd, logic [3:0] idx, logic signed [31:0] x, logic signed [31:0] y,
                  logic signed [31:0] z, logic [16:0] u, logic [16:0] v, int gap);
      req_valid       <= 1'b1;
      req_command     <= cmd;
      req_point_index <= idx;
      req_coord_x     <= x;
      req_coord_y     <= y;
      req_coord_z     <= z;
      req_u_param     <= u;
      req_v_param     <= v;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      sb.note_word(cmd, idx, x, y, z, u, v);
      sent++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task load_point(logic [3:0] idx, logic signed [31:0] x, logic signed [31:0] y,
                   logic signed [31:0] z);
      send_word(bbpe_pkg::CMD_LOAD, idx, x, y, z, pick_param(), pick_param(), pick_gap());
   endtask

   task eval_at(logic [16:0] u, logic [16:0] v);
      send_word(bbpe_pkg::CMD_EVAL, 4'($urandom), $urandom, $urandom, $urandom, u, v,
                pick_gap());
   endtask

   // Receiver: random stalls, plus long hold-offs on request.
   initial begin
      int hold;
      surface_point_type got;
      hold = 0;
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) begin
            got.pos[0] = rsp_pos_x;
            got.pos[1] = rsp_pos_y;
            got.pos[2] = rsp_pos_z;
            got.norm[0] = rsp_norm_x;
            got.norm[1] = rsp_norm_y;
            got.norm[2] = rsp_norm_z;
            got.degen = rsp_normal_degenerate;
            sb.check_result(got);
         end
         if (hold_request && hold == 0)
            hold = 5000;
         if (hold > 0) begin
            hold--;
            if (hold == 0)
               hold_request = 0;
            rsp_ready <= 1'b0;
         end else if (reset) begin
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) < 75) ||
                         (cycles % 4000 < 400) ? 1'b1 : 1'b0;
         end
      end
   end

   initial begin
      int n_loads;
      sb.reset_store();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // A flat patch whose corner tangents vanish, so the fallback normal is used.
      for (int i = 0; i < 16; i++)
         load_point(4'(i), 0, 0, 0);
      load_point(7, 32'sh10000, 0, 0);
      load_point(15, 0, 32'sh10000, 0);
      eval_at(0, 0);
      // All points equal gives a degenerate normal.
      load_point(7, 0, 0, 0);
      load_point(15, 0, 0, 0);
      eval_at(65536, 65536);
      // Extreme coordinates and parameters above one.
      load_point(0, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff);
      load_point(5, 32'sh80000000, 32'sh7fffffff, 32'sh80000000);
      load_point(10, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000);
      eval_at(17'h1ffff, 17'h1ffff);
      eval_at(32768, 0);
      eval_at(0, 65536);

      while (sent < 1050) begin
         if (sent > 300 && sent < 320 && !hold_request && sb.evals < 200)
            hold_request = 1;
         if (sent >= 600 && !drained) begin
            drained = 1;
            req_valid <= 1'b0;
            wait (sb.pending_points.size() == 0);
            @(posedge clock);
         end
         n_loads = ($urandom_range(9) == 0) ? 16 : $urandom_range(0, 4);
         for (int i = 0; i < n_loads; i++)
            load_point(n_loads == 16 ? 4'(i) : 4'($urandom_range(15)), pick_coord(),
                       pick_coord(), pick_coord());
         repeat ($urandom_range(1, 2))
            eval_at(pick_param(), pick_param());
      end
      req_valid <= 1'b0;

      wait (sb.pending_points.size() == 0);
      repeat (500) @(posedge clock);
      $display("Covered %0d loads and %0d evaluations (%0d fallback normals, %0d degenerate).",
               sb.loads, sb.evals, sb.fallbacks, sb.degenerates);
      if (sb.mismatches == 0 && sb.pending_points.size() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end
endmodule

`default_nettype wire

// File: filelist.f
+incdir+hw/rtl
hw/rtl/bbpe_pkg.sv
hw/rtl/bbpe_ram.sv
hw/rtl/bbpe_front.sv
hw/rtl/bbpe_back.sv
hw/rtl/bicubic_bezier_patch_eval.sv
hw/rtl/bbpe_checker.sv
tb/tb_top.sv
